// ----- rtl/hex_command_i2c_bridge_macros.svh -----
// Assertion helpers shared by the RTL that carries checks.
// Both sample on clk and are disabled while arst_n is low.
`ifndef HEX_COMMAND_I2C_BRIDGE_MACROS_SVH
`define HEX_COMMAND_I2C_BRIDGE_MACROS_SVH

// same-cycle implication
`define HCIB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HCIB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hcib_pkg.sv -----
// ---------------------------------------------------------------------------
// hcib_pkg
// Shared constants, codes, types and hex helpers of the hex command bridge.
// ---------------------------------------------------------------------------
`default_nettype none
package hcib_pkg;
	localparam int MAX_BYTES = 16;
	localparam int IDX_W     = $clog2(MAX_BYTES);
	localparam int LINE_CAP  = 2 * MAX_BYTES + 8;
	localparam int LEN_W     = 6;

	localparam logic [7:0] CH_WRITE = 8'h3e; // '>'
	localparam logic [7:0] CH_READ  = 8'h3c; // '<'
	localparam logic [7:0] CH_WRRD  = 8'h7c; // '|'
	localparam logic [7:0] CH_BANG  = 8'h21; // '!'
	localparam logic [7:0] CH_COLON = 8'h3a; // ':'

	localparam logic [15:0] ERR_SHORT   = 16'hffff;
	localparam logic [15:0] ERR_STATUS  = 16'hfffe;
	localparam logic [15:0] ERR_CODE_D  = 16'hfffd;
	localparam logic [15:0] ERR_CODE_C  = 16'hfffc;
	localparam logic [15:0] ERR_CODE_B  = 16'hfffb;
	localparam logic [15:0] ERR_CODE_A  = 16'hfffa;
	localparam logic [15:0] ERR_UNKNOWN = 16'hff00;

	localparam logic [1:0] ACT_CHAR   = 2'd0;
	localparam logic [1:0] ACT_BYTE   = 2'd1;
	localparam logic [1:0] ACT_STATUS = 2'd2;

	localparam logic [1:0] KIND_RESP  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [2:0] REG_CAPACITY = 3'd0;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] resp_char;
		logic [7:0] dev_addr;
		logic [4:0] xfer_count;
		logic [7:0] write_byte;
		logic       repeat_start;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [7:0]       wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
		return v;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] c;
		c = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
		return c;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/hex_command_i2c_bridge.sv -----
// ---------------------------------------------------------------------------
// hex_command_i2c_bridge
// ASCII hex command line to bus request bridge with APB configuration.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries command characters, bus read
// bytes and bus status beats, selected by action. Output channel
// (out_valid/out_ready) carries response characters, write request beats and
// read request beats; last closes each run.
// At the line end ST_FIN checks the line, then the reply or request run
// follows: error replies and read requests are loaded directly from ST_ERR and
// ST_RDREQ, while write bytes and read data characters each pass through a
// byte store read state first, since the store has registered read data.
// in_ready is low while a run is being produced. A stalled receiver holds
// the output register and the sequencer waits on it.
// Reset returns to line collection with empty counters and out_capacity 255;
// the byte store itself needs no clearing.
// out_capacity is at APB address 0.
`default_nettype none
`include "hex_command_i2c_bridge_macros.svh"
module hex_command_i2c_bridge (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  cmd_char,
	input  wire logic        line_end,
	input  wire logic [7:0]  bus_byte,
	input  wire logic [31:0] bus_status,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  kind,
	output logic      [7:0]  resp_char,
	output logic      [7:0]  dev_addr,
	output logic      [4:0]  xfer_count,
	output logic      [7:0]  write_byte,
	output logic             repeat_start,
	output logic             last
);
	logic [7:0]          cap_q;
	hcib_pkg::out_item_t item;
	hcib_pkg::ram_req_t  ram_req;
	logic [7:0]          ram_rdata;
	logic                cfg_wr;
	logic                resp_beat, req_zero;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == hcib_pkg::REG_CAPACITY);
	assign prdata = (paddr == hcib_pkg::REG_CAPACITY) ? {24'd0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= 8'hff;
		else if (cfg_wr) cap_q <= pwdata[7:0];
	end

	hcib_ram #(.WIDTH(8), .DEPTH(hcib_pkg::MAX_BYTES)) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	hcib_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity   (cap_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.cmd_char   (cmd_char),
		.line_end   (line_end),
		.bus_byte   (bus_byte),
		.bus_status (bus_status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (item),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata)
	);

	assign kind         = item.kind;
	assign resp_char    = item.resp_char;
	assign dev_addr     = item.dev_addr;
	assign xfer_count   = item.xfer_count;
	assign write_byte   = item.write_byte;
	assign repeat_start = item.repeat_start;
	assign last         = item.last;

	assign resp_beat = out_valid && (kind == hcib_pkg::KIND_RESP);
	assign req_zero  = (dev_addr == 8'd0) && (xfer_count == 5'd0) && (write_byte == 8'd0);

	`HCIB_ASSERT_NOW(a_resp_clean, resp_beat, req_zero, "request fields on a response beat")
	`HCIB_ASSERT_NOW(a_req_clean, out_valid && !resp_beat, resp_char == 8'd0, "char on request")
	`HCIB_ASSERT_NOW(a_no_overlap, in_ready && out_valid && !out_ready, last, "input mid run")
	`HCIB_ASSERT_NEXT(a_cap_write, cfg_wr, cap_q == $past(pwdata[7:0]), "capacity write lost")
endmodule
`default_nettype wire

// ----- rtl/hcib_ram.sv -----
// ---------------------------------------------------------------------------
// hcib_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module hcib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/hcib_ctrl.sv -----
// ---------------------------------------------------------------------------
// hcib_ctrl
// Line parser, command checks and reply sequencer around the byte store.
// ---------------------------------------------------------------------------
`default_nettype none
module hcib_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [7:0]          capacity,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          action,
	input  wire logic [7:0]          cmd_char,
	input  wire logic                line_end,
	input  wire logic [7:0]          bus_byte,
	input  wire logic [31:0]         bus_status,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output hcib_pkg::out_item_t      out_item,
	output hcib_pkg::ram_req_t       ram_req,
	input  wire logic [7:0]          ram_rdata
);
	typedef enum logic [3:0] {
		ST_COLLECT, ST_WSTAT, ST_READ, ST_FIN, ST_ERR,
		ST_WR_RD, ST_WR_EMIT, ST_RDREQ, ST_DATA_RD, ST_DATA_EMIT
	} state_t;

	state_t                    state_q;
	logic [7:0]                cmd_q, addr_q, wl_q, rl_q;
	logic [hcib_pkg::LEN_W-1:0] len_q, fin_len_q, cnt_q, run_len_q;
	logic [3:0]                nib_q;
	logic [4:0]                bidx_q;
	logic [15:0]               err_q;
	logic                      rs_q;
	logic                      ov_q;
	hcib_pkg::out_item_t       item_q;

	logic                      acc, out_free, emit;
	logic [3:0]                hv;
	logic [7:0]                pv;
	logic [4:0]                k;
	logic [6:0]                n2;
	logic [8:0]                need;
	logic [5:0]                full;
	logic [15:0]               st_err;
	logic [hcib_pkg::LEN_W-1:0] didx;
	logic [3:0]                nib_sel;
	logic [7:0]                data_char;
	logic [15:0]               chk_err;
	logic                      chk_ok;

	function automatic hcib_pkg::out_item_t resp_item(input logic [7:0] ch, input logic lst);
		hcib_pkg::out_item_t it;
		it           = '0;
		it.kind      = hcib_pkg::KIND_RESP;
		it.resp_char = ch;
		it.last      = lst;
		return it;
	endfunction

	assign in_ready  = (state_q == ST_COLLECT) || (state_q == ST_WSTAT) ||
		(state_q == ST_READ);
	assign acc       = in_valid && in_ready;
	assign out_free  = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign out_item  = item_q;

	// a beat is loaded into the output register this cycle
	assign emit = out_free && (((state_q == ST_ERR) && (capacity != 8'd0)) ||
		(state_q == ST_WR_EMIT) || (state_q == ST_RDREQ) || (state_q == ST_DATA_EMIT));

	assign hv     = hcib_pkg::hex_value(cmd_char);
	assign pv     = {nib_q, hv};
	assign k      = 5'(len_q[hcib_pkg::LEN_W-1:1] - 5'd1);
	assign n2     = {wl_q[5:0], 1'b0};
	assign need   = {rl_q, 1'b1};
	assign full   = {rl_q[4:0], 1'b1};
	assign st_err = (bus_status[31:16] != 16'd0) ? hcib_pkg::ERR_STATUS : bus_status[15:0];
	assign didx   = cnt_q - 6'd1;

	// store writes: line data bytes while collecting, bus bytes while reading
	always_comb begin
		ram_req       = '0;
		ram_req.raddr = (state_q == ST_DATA_RD || state_q == ST_DATA_EMIT) ?
			didx[4:1] : cnt_q[3:0];
		if (acc && state_q == ST_COLLECT && action == hcib_pkg::ACT_CHAR &&
			len_q >= 6'd2 && !len_q[0]) begin
			ram_req.wdata = pv;
			if (cmd_q == hcib_pkg::CH_WRITE && k >= 5'd2 && k < 5'd18) begin
				ram_req.we    = 1'b1;
				ram_req.waddr = 4'(k - 5'd2);
			end else if (cmd_q == hcib_pkg::CH_WRRD && k >= 5'd3 && k < 5'd19) begin
				ram_req.we    = 1'b1;
				ram_req.waddr = 4'(k - 5'd3);
			end
		end else if (acc && state_q == ST_READ && action == hcib_pkg::ACT_BYTE &&
			{3'd0, bidx_q} < rl_q && bidx_q < 5'(hcib_pkg::MAX_BYTES)) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = bidx_q[3:0];
			ram_req.wdata = bus_byte;
		end
	end

	always_comb begin
		case (cnt_q)
			6'd1:    nib_sel = err_q[15:12];
			6'd2:    nib_sel = err_q[11:8];
			6'd3:    nib_sel = err_q[7:4];
			default: nib_sel = err_q[3:0];
		endcase
	end

	// undelivered read bytes show as 00
	always_comb begin
		if (cnt_q == 6'd0) data_char = hcib_pkg::CH_COLON;
		else if ({1'b0, didx[4:1]} >= bidx_q) data_char = 8'h30;
		else if (didx[0]) data_char = hcib_pkg::hex_char(ram_rdata[3:0]);
		else data_char = hcib_pkg::hex_char(ram_rdata[7:4]);
	end

	// line checks, in priority order per command
	always_comb begin
		chk_ok  = 1'b0;
		chk_err = hcib_pkg::ERR_UNKNOWN;
		if (cmd_q == hcib_pkg::CH_WRITE) begin
			if (fin_len_q < 6'd5) chk_err = hcib_pkg::ERR_SHORT;
			else if (wl_q > 8'd16) chk_err = hcib_pkg::ERR_CODE_D;
			else if (n2 + 7'd5 != {1'b0, fin_len_q}) chk_err = hcib_pkg::ERR_CODE_C;
			else chk_ok = 1'b1;
		end else if (cmd_q == hcib_pkg::CH_READ) begin
			if (fin_len_q != 6'd5) chk_err = hcib_pkg::ERR_SHORT;
			else if (rl_q > 8'd16) chk_err = hcib_pkg::ERR_CODE_D;
			else if ({1'b0, capacity} < need) chk_err = hcib_pkg::ERR_CODE_C;
			else chk_ok = 1'b1;
		end else if (cmd_q == hcib_pkg::CH_WRRD) begin
			if (fin_len_q < 6'd7) chk_err = hcib_pkg::ERR_SHORT;
			else if (wl_q > 8'd16) chk_err = hcib_pkg::ERR_CODE_D;
			else if (rl_q > 8'd16) chk_err = hcib_pkg::ERR_CODE_C;
			else if ({1'b0, capacity} < need) chk_err = hcib_pkg::ERR_CODE_B;
			else if (n2 + 7'd7 != {1'b0, fin_len_q}) chk_err = hcib_pkg::ERR_CODE_A;
			else chk_ok = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_COLLECT;
			cmd_q     <= '0;
			len_q     <= '0;
			fin_len_q <= '0;
			nib_q     <= '0;
			addr_q    <= '0;
			wl_q      <= '0;
			rl_q      <= '0;
			bidx_q    <= '0;
			err_q     <= '0;
			rs_q      <= 1'b0;
			cnt_q     <= '0;
			run_len_q <= '0;
			ov_q      <= 1'b0;
			item_q    <= '0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (state_q)
				ST_COLLECT: begin
					if (acc && action == hcib_pkg::ACT_CHAR) begin
						if (len_q == 6'd0) begin
							cmd_q  <= cmd_char;
							addr_q <= '0;
							wl_q   <= '0;
							rl_q   <= '0;
						end else if (len_q[0]) begin
							nib_q <= hv;
						end else if (k == 5'd0) begin
							addr_q <= pv;
						end else if (k == 5'd1) begin
							if (cmd_q == hcib_pkg::CH_READ) rl_q <= pv;
							else wl_q <= pv;
						end else if (k == 5'd2 && cmd_q == hcib_pkg::CH_WRRD) begin
							rl_q <= pv;
						end
						if (line_end) begin
							fin_len_q <= (len_q < 6'(hcib_pkg::LINE_CAP)) ?
								len_q + 6'd1 : len_q;
							len_q     <= '0;
							state_q   <= ST_FIN;
						end else if (len_q < 6'(hcib_pkg::LINE_CAP)) begin
							len_q <= len_q + 6'd1;
						end
					end
				end
				ST_FIN: begin
					cnt_q  <= '0;
					err_q  <= chk_err;
					rs_q   <= (cmd_q == hcib_pkg::CH_WRRD);
					bidx_q <= '0;
					if (!chk_ok) state_q <= ST_ERR;
					else if (cmd_q == hcib_pkg::CH_READ) state_q <= ST_RDREQ;
					else state_q <= ST_WR_RD;
				end
				ST_ERR: begin
					if (capacity == 8'd0) begin
						state_q <= ST_COLLECT;
					end else if (out_free) begin
						if (cnt_q == 6'd0)
							item_q <= resp_item(hcib_pkg::CH_BANG, capacity < 8'd5);
						else
							item_q <= resp_item(hcib_pkg::hex_char(nib_sel), cnt_q == 6'd4);
						if (cnt_q == 6'd4 || capacity < 8'd5) state_q <= ST_COLLECT;
						else cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_WR_RD: state_q <= ST_WR_EMIT;
				ST_WR_EMIT: begin
					if (out_free) begin
						item_q.kind         <= hcib_pkg::KIND_WRITE;
						item_q.resp_char    <= '0;
						item_q.dev_addr     <= addr_q;
						item_q.xfer_count   <= wl_q[4:0];
						item_q.write_byte   <= (wl_q == 8'd0) ? 8'd0 : ram_rdata;
						item_q.repeat_start <= rs_q;
						item_q.last         <= (wl_q == 8'd0) || ({2'd0, cnt_q} + 8'd1 == wl_q);
						if ((wl_q == 8'd0) || ({2'd0, cnt_q} + 8'd1 == wl_q)) begin
							state_q <= ST_WSTAT;
						end else begin
							cnt_q   <= cnt_q + 6'd1;
							state_q <= ST_WR_RD;
						end
					end
				end
				ST_WSTAT: begin
					if (acc && action == hcib_pkg::ACT_STATUS) begin
						if (bus_status != 32'd0 || cmd_q != hcib_pkg::CH_WRRD) begin
							err_q   <= st_err;
							cnt_q   <= '0;
							state_q <= ST_ERR;
						end else begin
							bidx_q  <= '0;
							state_q <= ST_RDREQ;
						end
					end
				end
				ST_RDREQ: begin
					if (out_free) begin
						item_q.kind         <= hcib_pkg::KIND_READ;
						item_q.resp_char    <= '0;
						item_q.dev_addr     <= addr_q;
						item_q.xfer_count   <= rl_q[4:0];
						item_q.write_byte   <= '0;
						item_q.repeat_start <= 1'b0;
						item_q.last         <= 1'b1;
						state_q             <= ST_READ;
					end
				end
				ST_READ: begin
					if (acc && action == hcib_pkg::ACT_BYTE) begin
						if (bidx_q < 5'(hcib_pkg::MAX_BYTES)) bidx_q <= bidx_q + 5'd1;
					end else if (acc && action == hcib_pkg::ACT_STATUS) begin
						cnt_q <= '0;
						if (bus_status != 32'd0) begin
							err_q   <= st_err;
							state_q <= ST_ERR;
						end else if (capacity == 8'd0) begin
							state_q <= ST_COLLECT;
						end else begin
							run_len_q <= ({1'b0, capacity} < {3'd0, full}) ?
								capacity[5:0] : full;
							state_q   <= ST_DATA_RD;
						end
					end
				end
				ST_DATA_RD: state_q <= ST_DATA_EMIT;
				ST_DATA_EMIT: begin
					if (out_free) begin
						item_q <= resp_item(data_char, cnt_q + 6'd1 == run_len_q);
						if (cnt_q + 6'd1 == run_len_q) begin
							state_q <= ST_COLLECT;
						end else begin
							cnt_q   <= cnt_q + 6'd1;
							state_q <= ST_DATA_RD;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end
endmodule
`default_nettype wire
